// ===== rtl/core/damped_sinusoid_evaluator_macros.svh =====
// Assertion macros for the damped sinusoid evaluator.
`ifndef DAMPED_SINUSOID_EVALUATOR_MACROS_SVH
`define DAMPED_SINUSOID_EVALUATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DSE_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define DSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DSE_ASSERT_IMPL(label, clk, rst, ante, cons)
`define DSE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/dse_pkg.sv =====
// Shared constants, types and helpers for the damped sinusoid evaluator.
package dse_pkg;
  localparam int NUM_DIMS = 3;
  localparam int REG_COUNT = 3;
  localparam int NUM_STAGES = 22;

  typedef enum logic [1:0] {
    REG_DIM_COEF_0 = 2'd0,
    REG_DIM_COEF_1 = 2'd1,
    REG_DIM_COEF_2 = 2'd2,
    REG_NONE       = 2'd3
  } reg_index_t;

  localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] LOG2E_Q30    = 32'd1549082005;
  localparam logic [29:0] LN2_Q30      = 30'd744261118;
  localparam logic [35:0] EXP_LIMIT    = 36'd12 << 28;

  localparam logic [30:0] SIN_C0 = 31'd1686629713;
  localparam logic [30:0] SIN_C1 = 31'd693598668;
  localparam logic [30:0] SIN_C2 = 31'd85569306;
  localparam logic [30:0] SIN_C3 = 31'd5026995;
  localparam logic [30:0] SIN_C4 = 31'd172272;

  // reciprocals for exact division of a dividend below 2^30
  localparam logic [30:0] RCP3 = 31'd1431655766; // 2^32 / 3, rounded up
  localparam logic [30:0] RCP5 = 31'd1717986919; // 2^33 / 5, rounded up
  localparam logic [30:0] RCP6 = 31'd1431655766; // 2^33 / 6, rounded up
  localparam logic [30:0] RCP7 = 31'd1227133514; // 2^33 / 7, rounded up

  typedef struct packed {
    logic        neg;
    logic [30:0] x;
  } trig_t;
endpackage

// ===== rtl/core/dse_item_if.sv =====
// Valid/ready channel interfaces for items, results and register writes.
interface dse_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  dim_index;
  logic [31:0] time_value;
  modport source (output valid, dim_index, time_value, input ready);
  modport sink (input valid, dim_index, time_value, output ready);
endinterface

interface dse_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] coordinate;
  modport source (output valid, coordinate, input ready);
  modport sink (input valid, coordinate, output ready);
endinterface

interface dse_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/damped_sinusoid_evaluator.sv =====
// Damped sinusoid evaluator top level.
// Usage:
//  in  channel: dim_index and time_value, one beat per item.
//  out channel: coordinate, Q1.15, one beat per accepted item, in order.
//  cfg channel: index 0..2 writes dim_coef_N; other indexes are ignored.
//  Coefficient word: [15:0] damping Q4.12, [39:16] frequency signed Q8.16,
//  [63:40] phase as a fraction of a turn.
//  Even index gives exp(-d*t)*cos, odd gives sin; index 3 gives 0.
// Throughput: one item per cycle while the output is not stalled; every one of
// the 22 stages, including the multiply/subtract Horner steps, takes a new item each cycle.
// The whole pipeline advances only while the output stage is empty or
// taken, so a stalled receiver freezes every stage; nothing is lost.
// Input ready is high whenever the pipeline advances.
// Reset clears all valid bits and the coefficient registers to zero.
// Configuration ready is always high; write only while idle.
`include "damped_sinusoid_evaluator_macros.svh"
module damped_sinusoid_evaluator import dse_pkg::*; (
  input logic clk,
  input logic rst,
  dse_in_if.sink   in_ch,
  dse_out_if.source out_ch,
  dse_cfg_if.sink  cfg
);
  logic [63:0] coefs [REG_COUNT];
  logic        en, pv;
  logic [63:0] sel;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) coefs[i] <= '0;
    end else if (cfg.valid) begin
      unique case (reg_index_t'(cfg.index))
        REG_DIM_COEF_0: coefs[0] <= cfg.data;
        REG_DIM_COEF_1: coefs[1] <= cfg.data;
        REG_DIM_COEF_2: coefs[2] <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index_t'(in_ch.dim_index))
      REG_DIM_COEF_0: sel = coefs[0];
      REG_DIM_COEF_1: sel = coefs[1];
      REG_DIM_COEF_2: sel = coefs[2];
      default:        sel = '0;
    endcase
  end

  assign en = !pv || out_ch.ready;
  assign in_ch.ready = en;
  assign out_ch.valid = pv;

  dse_pipe u_pipe (
    .clk, .rst, .en,
    .in_valid(in_ch.valid),
    .dim_index(in_ch.dim_index),
    .time_value(in_ch.time_value),
    .coef(sel),
    .out_valid(pv),
    .coordinate(out_ch.coordinate)
  );

  `DSE_ASSERT_IMPL(a_ready, clk, rst, pv && !out_ch.ready, !in_ch.ready)
  `DSE_ASSERT_NEXT(a_keep, clk, rst, pv && !out_ch.ready, pv)
  `DSE_ASSERT_NEXT(a_data, clk, rst, pv && !out_ch.ready, $stable(out_ch.coordinate))
endmodule

// ===== rtl/core/dse_mulq.sv =====
// Registered 31 x 31 unsigned multiply returning the product scaled down by 2^30.
module dse_mulq (
  input  logic        clk,
  input  logic        en,
  input  logic [30:0] a,
  input  logic [30:0] b,
  output logic [30:0] p
);
  logic [61:0] prod;
  assign prod = a * b;
  always_ff @(posedge clk) begin
    if (en) begin
      p <= prod[60:30];
    end
  end
endmodule

// ===== rtl/core/dse_pipe.sv =====
// Datapath pipeline: angle, quarter sine, damping exponent and product.
`include "damped_sinusoid_evaluator_macros.svh"
module dse_pipe import dse_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [1:0]  dim_index,
  input  logic [31:0] time_value,
  input  logic [63:0] coef,
  output logic        out_valid,
  output logic [15:0] coordinate
);
  logic [NUM_STAGES-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NUM_STAGES-2:0], in_valid};
    end
  end
  assign out_valid = vld[NUM_STAGES-1];

  // stage 1: capture
  logic [15:0] s1_damp;
  logic [23:0] s1_freq;
  logic [31:0] s1_phase;
  logic [31:0] s1_t;
  always_ff @(posedge clk) begin
    if (en) begin
      s1_damp  <= coef[15:0];
      s1_freq  <= coef[39:16];
      s1_phase <= {coef[63:40], 8'd0} + (dim_index[0] ? 32'd0 : QUARTER_TURN);
      s1_t     <= time_value;
    end
  end

  // stage 2: freq*t (low 32 bits) and damp*t
  logic [31:0] s2_ft;
  logic [31:0] s2_phase;
  logic [47:0] s2_dt;
  logic [31:0] ft_low;
  assign ft_low = {{8{s1_freq[23]}}, s1_freq} * s1_t;
  always_ff @(posedge clk) begin
    if (en) begin
      s2_ft    <= ft_low;
      s2_phase <= s1_phase;
      s2_dt    <= s1_damp * s1_t;
    end
  end

  // stage 3: angle fold, exponent limit
  trig_t       s3_trig;
  logic [31:0] ang;
  logic [35:0] s3_x;
  logic        s3_big;
  assign ang = s2_ft + s2_phase;
  always_ff @(posedge clk) begin
    if (en) begin
      s3_trig.neg  <= ang[31];
      s3_trig.x    <= ang[30] ? (Q30_ONE - {1'b0, ang[29:0]}) : {1'b0, ang[29:0]};
      s3_big       <= s2_dt >= 48'(EXP_LIMIT);
      s3_x         <= s2_dt[35:0];
    end
  end

  // stage 4: x^2 and y = x*log2e
  logic [30:0] s4_x2;
  logic [35:0] s4_y;
  trig_t       s4_trig;
  logic        s4_big;
  logic [67:0] y_full;
  assign y_full = s3_x * LOG2E_Q30;
  dse_mulq u_x2 (clk, en, s3_trig.x, s3_trig.x, s4_x2);
  always_ff @(posedge clk) begin
    if (en) begin
      s4_y    <= y_full[65:30];
      s4_trig <= s3_trig;
      s4_big  <= s3_big;
    end
  end

  // stage 5: z = r*ln2
  logic [30:0] s5_z;
  logic [7:0]  s5_n;
  logic [57:0] z_full;
  assign z_full = s4_y[27:0] * LN2_Q30;
  always_ff @(posedge clk) begin
    if (en) begin
      s5_z <= {1'b0, z_full[57:28]};
      s5_n <= s4_big ? 8'd255 : {1'b0, s4_y[34:28]};
    end
  end

  // sine Horner: stages 5..13, two per step (mult, subtract)
  logic [30:0] sx2 [5:11];
  logic [30:0] sxx [5:12];
  logic        sng [5:12];
  logic [30:0] sp5, sp7, sp9, sp11;
  logic [30:0] sq6, sq8, sq10, sq12;
  always_ff @(posedge clk) begin
    if (en) begin
      sx2[5] <= s4_x2; sxx[5] <= s4_trig.x; sng[5] <= s4_trig.neg;
      for (int i = 6; i <= 12; i++) begin
        sxx[i] <= sxx[i-1]; sng[i] <= sng[i-1];
      end
      for (int i = 6; i <= 11; i++) sx2[i] <= sx2[i-1];
      sp5  <= SIN_C4;
      sp7  <= SIN_C3 - sq6;
      sp9  <= SIN_C2 - sq8;
      sp11 <= SIN_C1 - sq10;
    end
  end
  dse_mulq u_s6 (clk, en, sx2[5], sp5, sq6);
  dse_mulq u_s8 (clk, en, sx2[7], sp7, sq8);
  dse_mulq u_s10 (clk, en, sx2[9], sp9, sq10);
  dse_mulq u_s12 (clk, en, sx2[11], sp11, sq12);
  logic [30:0] s13_p, s14_s;
  logic        s13_neg, s14_neg;
  logic [30:0] s13_x;
  always_ff @(posedge clk) begin
    if (en) begin
      s13_p <= SIN_C0 - sq12;
      s13_x <= sxx[12];
      s13_neg <= sng[12];
      s14_neg <= s13_neg;
    end
  end
  logic [61:0] sfin;
  assign sfin = s13_x * s13_p;
  always_ff @(posedge clk) begin
    if (en) begin
      s14_s <= 31'(sfin >> 30);
    end
  end

  // sine delay to meet the exponent at stage 20
  logic [30:0] sd [15:20];
  logic        snd [15:21];
  always_ff @(posedge clk) begin
    if (en) begin
      sd[15] <= s14_s; snd[15] <= s14_neg;
      for (int i = 16; i <= 20; i++) sd[i] <= sd[i-1];
      for (int i = 16; i <= 21; i++) snd[i] <= snd[i-1];
    end
  end

  // exp Horner, k = 8..1: a multiply stage then a divide/subtract stage per step;
  // the dividend stays below 2^30, so reciprocal multiplies are exact
  logic [30:0] ez [6:18];
  logic [7:0]  ex_n [6:19];
  logic [30:0] ep6, ep8, ep10, ep12, ep14, ep16, ep18;
  logic [30:0] eq7, eq9, eq11, eq13, eq15, eq17, eq19;
  logic [60:0] ed7, ed9, ed11, ed15;
  assign ed7  = eq7[29:0] * RCP7;
  assign ed9  = eq9[29:0] * RCP6;
  assign ed11 = eq11[29:0] * RCP5;
  assign ed15 = eq15[29:0] * RCP3;
  always_ff @(posedge clk) begin
    if (en) begin
      ez[6] <= s5_z; ex_n[6] <= s5_n;
      for (int i = 7; i <= 18; i++) ez[i] <= ez[i-1];
      for (int i = 7; i <= 19; i++) ex_n[i] <= ex_n[i-1];
      ep6  <= Q30_ONE - (s5_z >> 3);
      ep8  <= Q30_ONE - {3'd0, ed7[60:33]};
      ep10 <= Q30_ONE - {3'd0, ed9[60:33]};
      ep12 <= Q30_ONE - {3'd0, ed11[60:33]};
      ep14 <= Q30_ONE - (eq13 >> 2);
      ep16 <= Q30_ONE - {2'd0, ed15[60:32]};
      ep18 <= Q30_ONE - (eq17 >> 1);
    end
  end
  dse_mulq u_e7 (clk, en, ez[6], ep6, eq7);
  dse_mulq u_e9 (clk, en, ez[8], ep8, eq9);
  dse_mulq u_e11 (clk, en, ez[10], ep10, eq11);
  dse_mulq u_e13 (clk, en, ez[12], ep12, eq13);
  dse_mulq u_e15 (clk, en, ez[14], ep14, eq15);
  dse_mulq u_e17 (clk, en, ez[16], ep16, eq17);
  dse_mulq u_e19 (clk, en, ez[18], ep18, eq19);

  // stage 20: last step and shift by the integer part
  logic [30:0] e20;
  logic [30:0] elast;
  assign elast = Q30_ONE - eq19;
  always_ff @(posedge clk) begin
    if (en) begin
      e20 <= (ex_n[19] > 8'd31) ? 31'd0 : (elast >> ex_n[19][4:0]);
    end
  end

  // stage 21: product; stage 22: round, saturate
  logic [30:0] v21;
  logic [31:0] vr;
  logic [16:0] mag;
  dse_mulq u_v (clk, en, e20, sd[20], v21);
  assign vr  = {1'b0, v21} + 32'd16384;
  assign mag = vr[31:15];
  always_ff @(posedge clk) begin
    if (en) begin
      if (snd[21]) begin
        coordinate <= (mag > 17'd32768) ? 16'h8000 : 16'(17'h10000 - mag);
      end else begin
        coordinate <= (mag > 17'd32767) ? 16'h7FFF : mag[15:0];
      end
    end
  end

  `DSE_ASSERT_NEXT(a_hold, clk, rst, !en, $stable(vld))
  `DSE_ASSERT_NEXT(a_shift, clk, rst, en && in_valid, vld[0])
  `DSE_ASSERT_NEXT(a_drain, clk, rst, en && !vld[NUM_STAGES-2], !out_valid)
endmodule

// ===== tb/damped_sinusoid_evaluator_tb.sv =====
// Testbench for damped_sinusoid_evaluator: random and directed items, fixed-point predictor.
`timescale 1ns / 100ps

module damped_sinusoid_evaluator_tb;
  import dse_pkg::*;

  class coordinate_scoreboard;
    logic [63:0] coef_word [REG_COUNT];
    logic [15:0] expected_coords [$];
    int mismatches;

    function new();
      foreach (coef_word[i]) coef_word[i] = '0;
      mismatches = 0;
    endfunction

    function void write_coef(reg_index_t idx, logic [63:0] value);
      if (idx != REG_NONE) coef_word[idx] = value;
    endfunction

    function logic [63:0] quarter_sine(logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] p;
      logic [63:0] c [5];
      c[0] = SIN_C0; c[1] = SIN_C1; c[2] = SIN_C2; c[3] = SIN_C3; c[4] = SIN_C4;
      x2 = (x * x) >> 30;
      p = c[4];
      for (int k = 3; k >= 0; k--) p = c[k] - ((x2 * p) >> 30);
      return (x * p) >> 30;
    endfunction

    function logic [63:0] decay(logic [63:0] x);
      logic [63:0] y, r, z, p;
      int n;
      if (x >= 64'(EXP_LIMIT)) return 0;
      y = (x * 64'(LOG2E_Q30)) >> 30;
      n = int'(y >> 28);
      r = y & 64'h0FFF_FFFF;
      z = (r * 64'(LN2_Q30)) >> 28;
      p = 64'(Q30_ONE);
      for (int k = 8; k >= 1; k--) p = 64'(Q30_ONE) - (((z * p) >> 30) / 64'(k));
      return p >> n;
    endfunction

    function logic [15:0] coordinate_of(logic [1:0] dim, logic [31:0] t);
      logic [63:0] c, damp, freq, phase, angle, f, x, s, e, v, mag;
      logic [1:0] quad;
      c = (dim < NUM_DIMS) ? coef_word[dim] : '0;
      damp = {48'b0, c[15:0]};
      freq = {{40{c[39]}}, c[39:16]};
      phase = {40'b0, c[63:40]};
      angle = (freq * {32'b0, t} + (phase << 8)) & 64'hFFFF_FFFF;
      if (!dim[0]) angle = (angle + 64'(QUARTER_TURN)) & 64'hFFFF_FFFF;
      quad = angle[31:30];
      f = {34'b0, angle[29:0]};
      x = quad[0] ? 64'(Q30_ONE) - f : f;
      s = quarter_sine(x);
      e = decay(damp * {32'b0, t});
      v = (e * s) >> 30;
      mag = (v + 64'd16384) >> 15;
      if (quad[1]) begin
        if (mag > 32768) mag = 32768;
        return 16'((64'h10000 - mag) & 64'hFFFF);
      end
      if (mag > 32767) mag = 32767;
      return mag[15:0];
    endfunction

    function void note_item(logic [1:0] dim, logic [31:0] t);
      expected_coords = {expected_coords, coordinate_of(dim, t)};
    endfunction

    function void check_coordinate(logic [15:0] got);
      logic [15:0] want;
      if (expected_coords.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: coordinate %0d", $signed(got));
        return;
      end
      want = expected_coords.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("coordinate mismatch: expected %0d, got %0d", $signed(want), $signed(got));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  coordinate_scoreboard sb = new();

  dse_in_if in_ch();
  dse_out_if out_ch();
  dse_cfg_if cfg();

  damped_sinusoid_evaluator u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg(cfg.sink)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0; in_ch.dim_index = '0; in_ch.time_value = '0;
    out_ch.ready = 1'b0;
    cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) sb.note_item(in_ch.dim_index, in_ch.time_value);
      if (out_ch.valid && out_ch.ready) sb.check_coordinate(out_ch.coordinate);
    end
  end

  task automatic send_item(logic [1:0] dim, logic [31:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.dim_index <= dim;
    in_ch.time_value <= t;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_coef(reg_index_t idx, logic [63:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    sb.write_coef(idx, value);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.expected_coords.size() > 0) @(posedge clk);
    repeat (NUM_STAGES + 5) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [63:0] random_coef();
    logic [15:0] damp;
    damp = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4095));
    return {24'($urandom), 24'($urandom), damp};
  endfunction

  function automatic logic [31:0] random_time();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0003_FFFF);
      2: return $urandom_range(0, 32'h00FF_FFFF);
      default: return $urandom_range(0, 32'h0000_0FFF);
    endcase
  endfunction

  initial begin
    logic [31:0] edge_times [4];
    edge_times[0] = 32'h0; edge_times[1] = 32'h1;
    edge_times[2] = 32'h0001_0000; edge_times[3] = 32'hFFFF_FFFF;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int setting = 0; setting < 4; setting++) begin
      send_idle_pct = (setting == 0) ? 35 : (setting == 1) ? 48 : 0;
      recv_idle_pct = (setting == 0) ? 48 : (setting == 1) ? 35 : 0;
      case (setting)
        0: begin
          // cos 1, sin of a quarter turn, cos of a half turn: saturation both ways
          write_coef(REG_DIM_COEF_0, 64'h0);
          write_coef(REG_DIM_COEF_1, {24'h40_0000, 24'h0, 16'h0});
          write_coef(REG_DIM_COEF_2, {24'h80_0000, 24'h0, 16'h0});
          write_coef(REG_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
        end
        1: begin
          write_coef(REG_DIM_COEF_0, 64'hFFFF_FFFF_FFFF_FFFF);
          write_coef(REG_DIM_COEF_1, {24'hFF_FFFF, 24'h80_0000, 16'h0001});
          write_coef(REG_DIM_COEF_2, {24'h00_0000, 24'h7F_FFFF, 16'hFFFF});
        end
        default: begin
          write_coef(REG_DIM_COEF_0, random_coef());
          write_coef(REG_DIM_COEF_1, random_coef());
          write_coef(REG_DIM_COEF_2, random_coef());
        end
      endcase
      cfg.valid <= 1'b0;
      if (setting < 2)
        for (int d = 0; d < 4; d++)
          foreach (edge_times[k]) send_item(2'(d), edge_times[k]);
      for (int n = 0; n < 200; n++) send_item(2'($urandom_range(0, 3)), random_time());
      drain();
    end

    if (sb.mismatches == 0 && sb.expected_coords.size() == 0)
      $display("damped_sinusoid_evaluator_tb: done, clean");
    else
      $display("damped_sinusoid_evaluator_tb: done, errors");
    $finish;
  end

  initial begin
    #5ms;
    $display("damped_sinusoid_evaluator_tb: done, errors");
    $finish;
  end
endmodule
